[src/mexp_pkg.sv]
// Shared constants, codes and controller/datapath structs for the modular
// exponentiation block. No dependencies.

package mexp_pkg;

  localparam int WORD_BITS = 32;
  localparam int FIELD_W   = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CNT_W     = $clog2(WORD_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

  localparam logic [FIELD_W-1:0] EXPONENT_RESET = FIELD_W'(79);
  localparam logic [FIELD_W-1:0] MODULUS_RESET  = FIELD_W'(3337);

  typedef enum logic [1:0] {
    MUL_RED = 2'd0,
    MUL_ACC = 2'd1,
    MUL_SQ  = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     start;
    mul_sel_t sel;
    logic     wr_sq;
    logic     wr_acc;
    logic     shift_exp;
    logic     load_out;
  } mexp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic exp_zero;
    logic exp_lsb;
    logic exp_last;
    logic out_free;
    logic cfg_exp_zero;
  } mexp_sts_t;

endpackage

[src/mexp_ifs.sv]
// Valid/ready channel interfaces: base request, result and register write.
// Depends on mexp_pkg.

interface mexp_in_if import mexp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] base_value;
  modport source (output valid, output base_value, input ready);
  modport sink   (input valid, input base_value, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] power_result;
  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

interface mexp_cfg_if import mexp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/mexp_modmul.sv]
// Sequential interleaved multiply-and-reduce unit, one multiplier bit a cycle.
// Depends on mexp_pkg.

module mexp_modmul import mexp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] a_in,
  input  logic [WORD_BITS-1:0] b_in,
  input  logic [WORD_BITS:0]   m_in,
  output logic                 busy,
  output logic                 done,
  output logic [WORD_BITS-1:0] result
);

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] a_r, a_nxt;
  logic [WORD_BITS-1:0] b_r, b_nxt;
  logic [WORD_BITS:0]   m_r, m_nxt;

  logic [WORD_BITS+1:0] t_sum;
  logic [WORD_BITS+1:0] m1;
  logic [WORD_BITS+1:0] m2;
  logic [WORD_BITS+1:0] t_red;

  always_comb begin
    m1    = {1'b0, m_r};
    m2    = {m_r, 1'b0};
    t_sum = {1'b0, acc_r, 1'b0} + (b_r[WORD_BITS-1] ? {2'b00, a_r} : '0);
    if (t_sum >= m2) begin
      t_red = t_sum - m2;
    end else if (t_sum >= m1) begin
      t_red = t_sum - m1;
    end else begin
      t_red = t_sum;
    end
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(WORD_BITS - 1);
      acc_nxt = '0;
      a_nxt   = a_in;
      b_nxt   = b_in;
      m_nxt   = m_in;
    end else if (run_r) begin
      acc_nxt = t_red[WORD_BITS-1:0];
      b_nxt   = {b_r[WORD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
  end

  assign busy   = run_r;
  assign done   = done_r;
  assign result = acc_r;

`ifndef SYNTHESIS
  a_result_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, acc_r} < m_r))
    else $error("modmul result not reduced");
`endif

endmodule

[src/mexp_datapath.sv]
// Datapath: key registers, operand registers, multiply-and-reduce unit and
// result register. Depends on mexp_pkg, mexp_ifs and mexp_modmul.

module mexp_datapath import mexp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [FIELD_W-1:0] base_value,
  mexp_cfg_if.sink           cfg,
  mexp_out_if.source         res,
  input  mexp_cmd_t          cmd,
  output mexp_sts_t          sts
);

  logic [WORD_BITS-1:0] exponent_r, exponent_nxt;
  logic [WORD_BITS-1:0] modulus_r, modulus_nxt;
  logic [WORD_BITS-1:0] base_r, exp_r, acc_r, sq_r;
  logic [WORD_BITS:0]   m_r;
  logic [FIELD_W-1:0]   out_data_r;
  logic                 out_valid_r, out_valid_nxt;

  logic [WORD_BITS:0]   m_ext;
  logic [WORD_BITS-1:0] acc_init;
  logic [WORD_BITS-1:0] mul_a, mul_b, mul_res;
  logic                 mul_busy, mul_done;

  assign cfg.ready = 1'b1;

  always_comb begin
    exponent_nxt = exponent_r;
    modulus_nxt  = modulus_r;
    if (cfg.valid) begin
      case (cfg.index)
        REG_EXPONENT: exponent_nxt = cfg.data[WORD_BITS-1:0];
        REG_MODULUS:  modulus_nxt  = cfg.data[WORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r  <= EXPONENT_RESET[WORD_BITS-1:0];
      modulus_r   <= MODULUS_RESET[WORD_BITS-1:0];
      out_valid_r <= 1'b0;
    end else begin
      exponent_r  <= exponent_nxt;
      modulus_r   <= modulus_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // zero modulus stands for 2^WORD_BITS
  always_comb begin
    if (modulus_r == '0) begin
      m_ext = {1'b1, {WORD_BITS{1'b0}}};
    end else begin
      m_ext = {1'b0, modulus_r};
    end
    if (exponent_r == '0 || m_ext != (WORD_BITS+1)'(1)) begin
      acc_init = WORD_BITS'(1);
    end else begin
      acc_init = '0;
    end
  end

  always_comb begin
    case (cmd.sel)
      MUL_RED: begin
        mul_a = WORD_BITS'(1);
        mul_b = base_r;
      end
      MUL_ACC: begin
        mul_a = sq_r;
        mul_b = acc_r;
      end
      MUL_SQ: begin
        mul_a = sq_r;
        mul_b = sq_r;
      end
      default: begin
        mul_a = WORD_BITS'(1);
        mul_b = base_r;
      end
    endcase
  end

  mexp_modmul u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start),
    .a_in   (mul_a),
    .b_in   (mul_b),
    .m_in   (m_r),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      base_r <= base_value[WORD_BITS-1:0];
      exp_r  <= exponent_r;
      m_r    <= m_ext;
      acc_r  <= acc_init;
    end else begin
      if (cmd.wr_acc) begin
        acc_r <= mul_res;
      end
      if (cmd.shift_exp) begin
        exp_r <= exp_r >> 1;
      end
    end
    if (cmd.wr_sq) begin
      sq_r <= mul_res;
    end
    if (cmd.load_out) begin
      out_data_r <= FIELD_W'(acc_r);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign res.valid        = out_valid_r;
  assign res.power_result = out_data_r;

  assign sts.mul_busy     = mul_busy;
  assign sts.mul_done     = mul_done;
  assign sts.exp_zero     = (exp_r == '0);
  assign sts.exp_lsb      = exp_r[0];
  assign sts.exp_last     = (exp_r[WORD_BITS-1:1] == '0);
  assign sts.out_free     = !out_valid_r || res.ready;
  assign sts.cfg_exp_zero = (exponent_r == '0);

`ifndef SYNTHESIS
  a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || res.ready))
    else $error("result overwritten before it was taken");
`endif

endmodule

[src/mexp_ctrl.sv]
// Square-and-multiply sequencer: walks the exponent bits and drives the
// datapath through commands. Depends on mexp_pkg.

module mexp_ctrl import mexp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mexp_sts_t sts,
  output mexp_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_RED  = 7'b0000100,
    S_STEP = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_SQ   = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.sel   = MUL_RED;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = sts.cfg_exp_zero ? S_FIN : S_PREP;
        end
      end
      S_PREP: begin
        cmd.start = 1'b1;
        cmd.sel   = MUL_RED;
        state_nxt = S_RED;
      end
      S_RED: begin
        if (sts.mul_done) begin
          cmd.wr_sq = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.exp_zero) begin
          state_nxt = S_FIN;
        end else if (sts.exp_lsb) begin
          cmd.start = 1'b1;
          cmd.sel   = MUL_ACC;
          state_nxt = S_ACC;
        end else begin
          cmd.shift_exp = 1'b1;
          cmd.start     = 1'b1;
          cmd.sel       = MUL_SQ;
          state_nxt     = S_SQ;
        end
      end
      S_ACC: begin
        if (sts.mul_done) begin
          cmd.wr_acc    = 1'b1;
          cmd.shift_exp = 1'b1;
          if (sts.exp_last) begin
            state_nxt = S_FIN;
          end else begin
            cmd.start = 1'b1;
            cmd.sel   = MUL_SQ;
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        if (sts.mul_done) begin
          cmd.wr_sq = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !sts.mul_busy)
    else $error("multiply started while unit busy");
  a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mul_done |-> (state_r == S_RED || state_r == S_ACC || state_r == S_SQ))
    else $error("multiply finished with no step waiting");
`endif

endmodule

[src/modular_exponentiation.sv]
// Top level of the modular exponentiation block: base^exponent mod modulus.
// Depends on mexp_pkg, mexp_ifs, mexp_ctrl and mexp_datapath.
//
//   channel  dir  payload                      handshake
//   in_ch    in   base_value[31:0]             valid/ready
//   out_ch   out  power_result[31:0]           valid/ready
//   cfg_ch   in   index[7:0], data[31:0]       valid/ready (ready held high)
//
// A zero exponent skips the multiplies; otherwise the work per request grows
// with the exponent's bit length and its count of set bits. The
// multiply-and-reduce unit works one multiplier bit a cycle.
// Reset is synchronous and returns the keys to exponent 79, modulus 3337.
// A new request is taken while the previous result still waits in out_ch.

module modular_exponentiation import mexp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mexp_in_if.sink    in_ch,
  mexp_out_if.source out_ch,
  mexp_cfg_if.sink   cfg_ch
);

  mexp_cmd_t cmd;
  mexp_sts_t sts;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mexp_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .base_value (in_ch.base_value),
    .cfg        (cfg_ch),
    .res        (out_ch),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
